/* rtl/button_stepped_pwm_dimmer_macros.svh */
// assertion macros shared by the dimmer rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef BUTTON_STEPPED_PWM_DIMMER_MACROS_SVH
`define BUTTON_STEPPED_PWM_DIMMER_MACROS_SVH

// clocked check, disabled while reset is asserted
`define BSPD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BSPD_ASSERT_ALW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/bspd_pkg.sv */
// shared types and constants for the button stepped pwm dimmer
// no dependencies; imported by every rtl module of the block
`default_nettype none

package bspd_pkg;

	// register map, byte address bits [3:2]
	localparam logic [1:0] REG_PERIOD_TOP = 2'd0;
	localparam logic [1:0] REG_STEP_SIZE  = 2'd1;
	localparam logic [1:0] REG_PRESCALE   = 2'd2;
	localparam logic [1:0] REG_DEBOUNCE   = 2'd3;

	localparam int ADDR_W = 4;

	// register reset values
	localparam logic [15:0] PERIOD_TOP_RST = 16'd62500;
	localparam logic [12:0] STEP_SIZE_RST  = 13'd6250;
	localparam logic [10:0] PRESCALE_RST   = 11'd256;
	localparam logic [23:0] DEBOUNCE_RST   = 24'd320000;

	// duty step limits
	localparam logic [3:0] MIN_STEP = 4'd1;
	localparam logic [3:0] MAX_STEP = 4'd10;

	// prescaler limit
	localparam logic [10:0] PRESCALE_MAX = 11'd1024;

	// status from the press sequencer to the timer and output
	typedef struct packed {
		logic [3:0] duty_step;
		logic [3:0] duty_next;
		logic       busy;
	} press_stat_t;

endpackage

`default_nettype wire

/* rtl/bspd_press.sv */
// button press sequencer: debounce, hold, debounce, then duty step
// depends on bspd_pkg and button_stepped_pwm_dimmer_macros.svh
`default_nettype none

`include "button_stepped_pwm_dimmer_macros.svh"

module bspd_press (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  advance,
	input  wire                  up_button_n,
	input  wire                  down_button_n,
	input  wire  [23:0]          debounce_ticks,
	output bspd_pkg::press_stat_t stat
);
	import bspd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT1,
		PH_HELD,
		PH_WAIT2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        is_down_q, is_down_d;
	logic [23:0] deb_cnt_q, deb_cnt_d;
	logic [3:0]  duty_q, duty_d;

	logic [24:0] deb_inc;
	logic        deb_done;
	logic        held_level;

	// debounce wait ends when the next count reaches the limit
	assign deb_inc  = {1'b0, deb_cnt_q} + 25'd1;
	assign deb_done = deb_inc >= {1'b0, debounce_ticks};
	assign held_level = is_down_q ? down_button_n : up_button_n;

	// next state of the sequencer for one tick
	always_comb begin
		phase_d   = phase_q;
		is_down_d = is_down_q;
		deb_cnt_d = deb_cnt_q;
		duty_d    = duty_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (!up_button_n) begin
					is_down_d = 1'b0;
					phase_d   = PH_WAIT1;
					deb_cnt_d = '0;
				end else if (!down_button_n) begin
					is_down_d = 1'b1;
					phase_d   = PH_WAIT1;
					deb_cnt_d = '0;
				end
			end
			PH_WAIT1: begin
				deb_cnt_d = deb_done ? 24'd0 : deb_inc[23:0];
				if (deb_done) phase_d = PH_HELD;
			end
			PH_HELD: begin
				if (held_level) begin
					phase_d   = PH_WAIT2;
					deb_cnt_d = '0;
				end
			end
			PH_WAIT2: begin
				deb_cnt_d = deb_done ? 24'd0 : deb_inc[23:0];
				if (deb_done) begin
					phase_d = PH_IDLE;
					if (is_down_q) begin
						if (duty_q > MIN_STEP) duty_d = duty_q - 4'd1;
					end else begin
						if (duty_q < MAX_STEP) duty_d = duty_q + 4'd1;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// state registers, moved once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			is_down_q <= 1'b0;
			deb_cnt_q <= '0;
			duty_q    <= MIN_STEP;
		end else if (advance) begin
			phase_q   <= phase_d;
			is_down_q <= is_down_d;
			deb_cnt_q <= deb_cnt_d;
			duty_q    <= duty_d;
		end
	end

	assign stat.duty_step = duty_q;
	assign stat.duty_next = advance ? duty_d : duty_q;
	assign stat.busy      = phase_q != PH_IDLE;

	// checks
	`BSPD_ASSERT_RST(a_duty_range, clk, arst_n, (duty_q >= MIN_STEP) && (duty_q <= MAX_STEP), "duty step out of range")
	`BSPD_ASSERT_RST(a_duty_hold, clk, arst_n, !advance || (phase_q != PH_WAIT2) |=> $stable(duty_q), "duty moved outside release debounce")
	`BSPD_ASSERT_RST(a_idle_stay, clk, arst_n, advance && (phase_q == PH_IDLE) && up_button_n && down_button_n |=> phase_q == PH_IDLE, "press started with no button down")
	`BSPD_ASSERT_RST(a_up_wins, clk, arst_n, advance && (phase_q == PH_IDLE) && !up_button_n |=> !is_down_q, "up button lost priority")

endmodule

`default_nettype wire

/* rtl/bspd_timer.sv */
// prescaled fast pwm counter with compare latched at each period start
// depends on bspd_pkg
`default_nettype none

module bspd_timer (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        advance,
	input  wire [15:0] period_top,
	input  wire [12:0] step_size,
	input  wire [10:0] prescale_ticks,
	input  wire [3:0]  duty_next,
	output logic       pwm_level
);
	import bspd_pkg::*;

	logic [9:0]  pre_cnt_q;
	logic [15:0] period_q;
	logic [15:0] compare_q;

	logic [10:0] ticks;
	logic [10:0] pre_inc;
	logic        pre_wrap;
	logic        period_wrap;
	logic [16:0] product;
	logic [15:0] wanted;

	// clamp prescale to 1..1024
	always_comb begin
		priority if (prescale_ticks == 11'd0) ticks = 11'd1;
		else if (prescale_ticks > PRESCALE_MAX) ticks = PRESCALE_MAX;
		else ticks = prescale_ticks;
	end

	assign pre_inc     = {1'b0, pre_cnt_q} + 11'd1;
	assign pre_wrap    = pre_inc >= ticks;
	assign period_wrap = period_q >= period_top;

	// compare target, saturated to 16 bits
	assign product = 17'(duty_next) * 17'(step_size);
	assign wanted  = product[16] ? 16'hFFFF : product[15:0];

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_cnt_q <= '0;
			period_q  <= '0;
			compare_q <= 16'(STEP_SIZE_RST) * 16'(MIN_STEP);
		end else if (advance) begin
			if (pre_wrap) begin
				pre_cnt_q <= '0;
				if (period_wrap) begin
					period_q  <= '0;
					compare_q <= wanted;
				end else begin
					period_q <= period_q + 16'd1;
				end
			end else begin
				pre_cnt_q <= pre_inc[9:0];
			end
		end
	end

	assign pwm_level = period_q <= compare_q;

endmodule

`default_nettype wire

/* rtl/button_stepped_pwm_dimmer.sv */
// Output: a result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the output register alone sets the pace and
// s_tready drops only while a held result is not taken.
// Reset: arst_n clears counters, press state and output valid at once;
// registers return to 62500, 6250, 256, 320000 and the duty step to one.
// Depends on bspd_pkg, bspd_press and bspd_timer.
`default_nettype none

module button_stepped_pwm_dimmer (
	input  wire        clk,
	input  wire        arst_n,
	// input stream
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [0] up_button_n, [1] down_button_n, [7:2] zero
	// result stream
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [0] pwm_level, [4:1] duty_step, [5] button_busy, [7:6] zero
	// configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [bspd_pkg::ADDR_W-1:0]  paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bspd_pkg::*;

	logic [15:0] period_top_q;
	logic [12:0] step_size_q;
	logic [10:0] prescale_q;
	logic [23:0] debounce_q;

	logic        advance;
	logic        cfg_wr;
	logic        pwm_level;
	press_stat_t stat;

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q <= PERIOD_TOP_RST;
			step_size_q  <= STEP_SIZE_RST;
			prescale_q   <= PRESCALE_RST;
			debounce_q   <= DEBOUNCE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PERIOD_TOP: period_top_q <= pwdata[15:0];
				REG_STEP_SIZE:  step_size_q  <= pwdata[12:0];
				REG_PRESCALE:   prescale_q   <= pwdata[10:0];
				REG_DEBOUNCE:   debounce_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_PERIOD_TOP: prdata = {16'd0, period_top_q};
			REG_STEP_SIZE:  prdata = {19'd0, step_size_q};
			REG_PRESCALE:   prdata = {21'd0, prescale_q};
			REG_DEBOUNCE:   prdata = {8'd0, debounce_q};
			default:        prdata = '0;
		endcase
	end

	// a word is taken whenever the output register is free or draining
	assign s_tready = !m_tvalid_q || m_tready;
	assign advance  = s_tvalid && s_tready;

	bspd_press u_press (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.up_button_n    (s_tdata[0]),
		.down_button_n  (s_tdata[1]),
		.debounce_ticks (debounce_q),
		.stat           (stat)
	);

	bspd_timer u_timer (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.period_top     (period_top_q),
		.step_size      (step_size_q),
		.prescale_ticks (prescale_q),
		.duty_next      (stat.duty_next),
		.pwm_level      (pwm_level)
	);

	// result register, shows state as it was when the word arrived
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {2'b00, stat.busy, stat.duty_step, pwm_level};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for button_stepped_pwm_dimmer: button words in, pwm/duty/busy words out
// predicts every result word from its own dimmer model; needs bspd_pkg and the dimmer rtl

module testbench;
	import bspd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;

	typedef enum logic [1:0] {
		PRESS_IDLE,
		PRESS_SETTLE_IN,
		PRESS_HELD,
		PRESS_SETTLE_OUT
	} press_phase_t;

	typedef struct packed {
		logic       busy;
		logic [3:0] duty;
		logic       pwm;
	} dimmer_out_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = 8'd0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [ADDR_W-1:0]   paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	// register copies and dimmer state of the predictor
	logic [15:0]  cfg_top      = PERIOD_TOP_RST;
	logic [12:0]  cfg_step     = STEP_SIZE_RST;
	logic [10:0]  cfg_prescale = PRESCALE_RST;
	logic [23:0]  cfg_debounce = DEBOUNCE_RST;
	logic [9:0]   dim_pre_cnt    = '0;
	logic [15:0]  dim_period_cnt = '0;
	logic [15:0]  dim_compare    = 16'(STEP_SIZE_RST);
	logic [3:0]   dim_duty       = MIN_STEP;
	press_phase_t dim_phase      = PRESS_IDLE;
	logic         dim_is_down    = 1'b0;
	logic [23:0]  dim_settle_cnt = '0;

	// bit 0 up_button_n, bit 1 down_button_n
	logic [1:0]  button_q[$];
	dimmer_out_t dimmer_out_q[$];

	int          words_queued  = 0;
	int          words_taken   = 0;
	int          results_seen  = 0;
	int          mismatches    = 0;
	int          stall_cycles  = 0;
	logic        word_in_taken = 1'b0;
	int unsigned send_gap      = 0;
	int unsigned send_calm     = 0;
	int unsigned take_gap      = 0;
	int unsigned take_calm     = 0;
	int unsigned hold_left     = 0;
	int          hold_asks     = 0;
	int          hold_done     = 0;

	button_stepped_pwm_dimmer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 40) begin
			$display("%0t: result %0d: %s", $realtime, results_seen, what);
		end
		mismatches++;
	endtask

	// one tick of the dimmer: emit the levels at tick start, then update
	task automatic dimmer_tick(input logic up_n, input logic down_n);
		dimmer_out_t res;
		logic        settle_end;
		int          div;
		int          want_cmp;
		res.pwm  = (dim_period_cnt <= dim_compare);
		res.duty = dim_duty;
		res.busy = (dim_phase != PRESS_IDLE);
		dimmer_out_q.push_back(res);

		// press sequencer
		settle_end = (int'(dim_settle_cnt) + 1 >= int'(cfg_debounce));
		case (dim_phase)
			PRESS_IDLE: begin
				if (!up_n) begin
					dim_is_down    = 1'b0;
					dim_phase      = PRESS_SETTLE_IN;
					dim_settle_cnt = '0;
				end else if (!down_n) begin
					dim_is_down    = 1'b1;
					dim_phase      = PRESS_SETTLE_IN;
					dim_settle_cnt = '0;
				end
			end
			PRESS_SETTLE_IN: begin
				if (settle_end) begin
					dim_settle_cnt = '0;
					dim_phase      = PRESS_HELD;
				end else begin
					dim_settle_cnt = dim_settle_cnt + 24'd1;
				end
			end
			PRESS_HELD: begin
				if ((dim_is_down ? down_n : up_n) != 1'b0) begin
					dim_phase      = PRESS_SETTLE_OUT;
					dim_settle_cnt = '0;
				end
			end
			default: begin
				if (settle_end) begin
					dim_settle_cnt = '0;
					if (dim_is_down) begin
						if (dim_duty > MIN_STEP) dim_duty = dim_duty - 4'd1;
					end else if (dim_duty < MAX_STEP) begin
						dim_duty = dim_duty + 4'd1;
					end
					dim_phase = PRESS_IDLE;
				end else begin
					dim_settle_cnt = dim_settle_cnt + 24'd1;
				end
			end
		endcase

		// prescaler and period counter, compare latched at wrap
		div = int'(cfg_prescale);
		if (div < 1) div = 1;
		if (div > int'(PRESCALE_MAX)) div = int'(PRESCALE_MAX);
		if (int'(dim_pre_cnt) + 1 >= div) begin
			dim_pre_cnt = '0;
			if (dim_period_cnt >= cfg_top) begin
				dim_period_cnt = '0;
				want_cmp = int'(dim_duty) * int'(cfg_step);
				dim_compare = (want_cmp > 65535) ? 16'hFFFF : 16'(want_cmp);
			end else begin
				dim_period_cnt = dim_period_cnt + 16'd1;
			end
		end else begin
			dim_pre_cnt = dim_pre_cnt + 10'd1;
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// check result words, then predict for the accepted button word
	always @(posedge clk) begin : monitor
		dimmer_out_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (dimmer_out_q.size() == 0) begin
					report_mismatch("result word arrived with nothing pending");
				end else begin
					want = dimmer_out_q.pop_front();
					if (m_tdata[0] !== want.pwm)
						report_mismatch($sformatf("pwm_level %b, want %b", m_tdata[0], want.pwm));
					if (m_tdata[4:1] !== want.duty)
						report_mismatch($sformatf("duty_step %0d, want %0d",
							m_tdata[4:1], want.duty));
					if (m_tdata[5] !== want.busy)
						report_mismatch($sformatf("button_busy %b, want %b",
							m_tdata[5], want.busy));
				end
				results_seen++;
			end
			if (s_tvalid && s_tready) begin
				dimmer_tick(s_tdata[0], s_tdata[1]);
				words_taken++;
			end
		end
		word_in_taken <= arst_n && s_tvalid && s_tready;
	end

	// no handshake on either side for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("button_stepped_pwm_dimmer test failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// button word driver with random gaps and gap-free stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_in_taken) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (button_q.size() != 0) begin
				s_tdata  <= {6'd0, button_q.pop_front()};
				s_tvalid <= 1'b1;
				if (send_calm != 0) begin
					send_calm <= send_calm - 1;
				end else begin
					send_gap <= pick_gap();
					if ($urandom_range(0, 49) == 0) send_calm <= $urandom_range(20, 100);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus requested long hold-offs
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_asks != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (take_gap != 0) begin
			take_gap <= take_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (take_calm != 0) begin
				take_calm <= take_calm - 1;
			end else begin
				if ($urandom_range(0, 2) == 0) take_gap <= pick_gap();
				if ($urandom_range(0, 59) == 0) take_calm <= $urandom_range(20, 100);
			end
		end
	end

	task automatic queue_word(input logic up_n, input logic down_n);
		button_q.push_back({down_n, up_n});
		words_queued++;
	endtask

	task automatic queue_idle(input int count);
		repeat (count) queue_word(1'b1, 1'b1);
	endtask

	task automatic queue_press(input logic up_n, input logic down_n, input int hold,
			input int rest);
		repeat (hold) queue_word(up_n, down_n);
		queue_idle(rest);
	endtask

	// mostly clean presses of random length, some bouncing, some line noise
	task automatic queue_press_traffic(input int count, input int unsigned up_pct);
		int          start;
		int unsigned span;
		int unsigned kind;
		logic        up_n;
		logic        down_n;
		logic        noisy;
		start = words_queued;
		span  = (cfg_debounce > 24'd20) ? 20 : int'(cfg_debounce) + 2;
		while (words_queued - start < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				repeat ($urandom_range(1, 6))
					queue_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				up_n   = 1'b1;
				down_n = 1'b1;
				if (kind < 18) begin
					up_n   = 1'b0;
					down_n = 1'b0;
				end else if ($urandom_range(0, 99) < up_pct) begin
					up_n = 1'b0;
				end else begin
					down_n = 1'b0;
				end
				noisy = ($urandom_range(0, 4) == 0);
				repeat ($urandom_range(1, 2 * span)) begin
					if (noisy && $urandom_range(0, 2) == 0)
						queue_word(up_n ^ 1'($urandom_range(0, 1)),
							down_n ^ 1'($urandom_range(0, 1)));
					else
						queue_word(up_n, down_n);
				end
				queue_idle($urandom_range(1, 2 * span + 1));
			end
		end
	endtask

	task automatic wait_drained();
		while (words_taken != words_queued || dimmer_out_q.size() != 0) @(negedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// registers change only once every result word is back
	task automatic set_config(input logic [15:0] top, input logic [12:0] step,
			input logic [10:0] prescale, input logic [23:0] debounce);
		wait_drained();
		apb_write(REG_PERIOD_TOP, 32'(top));
		apb_write(REG_STEP_SIZE, 32'(step));
		apb_write(REG_PRESCALE, 32'(prescale));
		apb_write(REG_DEBOUNCE, 32'(debounce));
		cfg_top      = top;
		cfg_step     = step;
		cfg_prescale = prescale;
		cfg_debounce = debounce;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: the long default debounce keeps this press busy
		queue_idle(4);
		queue_press(1'b0, 1'b1, 1, 2);

		// no debounce: up, down, down at the floor, both lines, chatter on the other line
		set_config(16'd3, 13'd1, 11'd1, 24'd0);
		queue_press(1'b0, 1'b1, 2, 2);
		queue_press(1'b1, 1'b0, 2, 2);
		queue_press(1'b1, 1'b0, 1, 2);
		queue_press(1'b1, 1'b0, 1, 2);
		queue_press(1'b0, 1'b0, 2, 2);
		queue_word(1'b1, 1'b0);
		queue_word(1'b0, 1'b0);
		queue_word(1'b0, 1'b0);
		queue_press(1'b1, 1'b1, 0, 2);

		// top and step at zero, prescaler zero acts as one
		set_config(16'd0, 13'd0, 11'd0, 24'd1);
		queue_press_traffic(150, 50);

		// prescaler beyond its limit, counter steps once per 1024 ticks
		set_config(16'd1, 13'd0, 11'd2047, 24'd3);
		queue_press_traffic(300, 50);

		// widest period, largest step that does not saturate, duty pushed past its ceiling
		set_config(16'd65535, 13'd6553, 11'd1, 24'd2);
		repeat (12) queue_press(1'b0, 1'b1, 1, 3);
		queue_press_traffic(100, 50);

		// longest debounce: the press is still settling when the phase ends
		set_config(16'd40, 13'd3, 11'd1024, 24'd16777215);
		queue_press(1'b1, 1'b0, 2, 2);
		queue_idle(30);

		// step past the range saturates the compare target, latched every tick
		set_config(16'd0, 13'd6554, 11'd1, 24'd0);
		repeat (12) queue_press(1'b0, 1'b1, 1, 3);
		queue_press(1'b1, 1'b0, 1, 2);

		// long period: count climbs past where a wrapped compare would sit
		set_config(16'd65535, 13'd8191, 11'd1, 24'd0);
		queue_idle(300);

		// random small settings so presses and periods turn over quickly
		for (int p = 0; p < 8; p++) begin
			set_config(16'($urandom_range(0, 40)), 13'($urandom_range(0, 8)),
				11'($urandom_range(0, 4)), 24'($urandom_range(0, 6)));
			queue_press_traffic(120, (p % 2 != 0) ? 70 : 30);
			if (p == 2 || p == 5) hold_asks++;
		end

		wait_drained();
		repeat (6) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0) begin
			$display("button_stepped_pwm_dimmer test passed");
		end else begin
			$display("button_stepped_pwm_dimmer test failed");
		end
		$finish;
	end

endmodule
